>>> rtl/lfpd_pkg.sv
// shared types and constants for the line-follow pd motor mixer
// used by all rtl files of the block, depends on nothing

package lfpd_pkg;

  // input opcodes
  localparam int unsigned OP_W = 2;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_START  = 2'd2;
  localparam logic [OP_W-1:0] OP_STOP   = 2'd3;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_LIMIT = 3'd4;

  // register reset values
  localparam logic [15:0] KP_GAIN_RST    = 16'd589;
  localparam logic [15:0] KD_GAIN_RST    = 16'd5120;
  localparam logic [14:0] MAX_PERIOD_RST = 15'd1000;
  localparam logic [11:0] DARK_LEVEL_RST = 12'd900;
  localparam logic [15:0] DARK_LIMIT_RST = 16'd100;

  // clamp limit 4*p/5 by reciprocal multiply, exact for 17-bit numerators
  localparam int unsigned LIM_SHIFT = 21;
  localparam logic [18:0] LIM_RECIP = 19'd419431;

  typedef struct packed {
    logic [15:0] kp_gain;
    logic [15:0] kd_rate_gain;
    logic [14:0] max_period;
    logic [11:0] dark_level;
    logic [15:0] dark_count_limit;
  } lfpd_cfg_t;

  // stage load strobes, one per pipeline stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } lfpd_load_t;

  // per-tick side data that travels with the steering path
  typedef struct packed {
    logic              run;
    logic              course_out;
    logic signed [15:0] vel;
  } lfpd_meta_t;

endpackage

>>> rtl/lfpd_sense.sv
// sensor store with running sums, course-out counter and half means
// depends on lfpd_pkg

module lfpd_sense #(
  parameter int unsigned SENSOR_COUNT = 12,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lfpd_pkg::lfpd_load_t            load_i,
  input  logic [lfpd_pkg::OP_W-1:0]       opcode_i,
  input  logic [3:0]                      sensor_index_i,
  input  logic [11:0]                     sensor_value_i,
  input  logic signed [15:0]              velocity_term_i,
  input  lfpd_pkg::lfpd_cfg_t             cfg_i,
  output logic [SAMPLE_BITS-1:0]          left_mean_o,
  output logic [SAMPLE_BITS-1:0]          right_mean_o,
  output lfpd_pkg::lfpd_meta_t            meta_o
);

  localparam int unsigned HALF = SENSOR_COUNT / 2;
  localparam int unsigned IW   = $clog2(SENSOR_COUNT);
  localparam int unsigned TW   = SAMPLE_BITS + $clog2(SENSOR_COUNT);
  localparam int unsigned HW   = SAMPLE_BITS + $clog2(HALF);
  localparam int unsigned SH   = HW + $clog2(HALF) + 1;
  localparam int unsigned MW   = HW + 2;
  localparam longint unsigned MH_VAL = ((64'd1 << SH) + HALF - 1) / HALF;
  localparam logic [MW-1:0]   MH   = MW'(MH_VAL);
  localparam int unsigned THW  = 13 + $clog2(SENSOR_COUNT + 1);
  localparam int unsigned CW   = (TW > THW) ? TW : THW;

  logic [SAMPLE_BITS-1:0] store_q [SENSOR_COUNT];
  logic [TW-1:0]          tot_q, tot_d;
  logic [HW-1:0]          lsum_q, lsum_d, rsum_q, rsum_d;
  logic                   running_q;
  logic [15:0]            cnt_q, cnt_d;

  logic [5:0]             idx_ext;
  logic                   in_range, is_left, is_right, wr, tick;
  logic [IW-1:0]          widx;
  logic [15:0]            val_ext;
  logic [SAMPLE_BITS-1:0] smp, old;
  logic [THW-1:0]         thr;
  logic                   dark;
  logic [HW+MW-1:0]       lprod, rprod;
  logic [SAMPLE_BITS-1:0] odd_val;

  // sample decode
  always_comb begin
    idx_ext  = {2'b00, sensor_index_i};
    in_range = idx_ext < 6'(SENSOR_COUNT);
    widx     = idx_ext[IW-1:0];
    is_left  = idx_ext < 6'(HALF);
    is_right = !is_left && (idx_ext < 6'(2 * HALF));
    val_ext  = {4'b0000, sensor_value_i};
    smp      = val_ext[SAMPLE_BITS-1:0];
    old      = in_range ? store_q[widx] : '0;
    wr       = load_i.s1 && (opcode_i == lfpd_pkg::OP_SAMPLE) && in_range;
    tick     = load_i.s1 && (opcode_i == lfpd_pkg::OP_TICK);
  end

  // running sums follow every store write
  always_comb begin
    tot_d  = tot_q - TW'(old) + TW'(smp);
    lsum_d = lsum_q;
    rsum_d = rsum_q;
    if (is_left) begin
      lsum_d = lsum_q - HW'(old) + HW'(smp);
    end
    if (is_right) begin
      rsum_d = rsum_q - HW'(old) + HW'(smp);
    end
  end

  // mean above dark level is the same as sum >= (level + 1) * count
  always_comb begin
    thr  = THW'({1'b0, cfg_i.dark_level} + 13'd1) * THW'(SENSOR_COUNT);
    dark = CW'(tot_q) >= CW'(thr);
    if (dark) begin
      cnt_d = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
    end else begin
      cnt_d = '0;
    end
  end

  // half means by reciprocal multiply
  always_comb begin
    lprod = (HW+MW)'(lsum_q) * (HW+MW)'(MH);
    rprod = (HW+MW)'(rsum_q) * (HW+MW)'(MH);
  end

  // state: store, sums, run flag, dark counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q   <= '{default: '0};
      tot_q     <= '0;
      lsum_q    <= '0;
      rsum_q    <= '0;
      running_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (wr) begin
        store_q[widx] <= smp;
        tot_q         <= tot_d;
        lsum_q        <= lsum_d;
        rsum_q        <= rsum_d;
      end
      if (load_i.s1 && (opcode_i == lfpd_pkg::OP_START)) begin
        running_q <= 1'b1;
      end
      if (load_i.s1 && (opcode_i == lfpd_pkg::OP_STOP)) begin
        running_q <= 1'b0;
      end
      if (tick) begin
        cnt_q <= cnt_d;
      end
    end
  end

  // stage 1 result register
  always_ff @(posedge clk_i) begin
    if (tick) begin
      left_mean_o       <= lprod[SH +: SAMPLE_BITS];
      right_mean_o      <= rprod[SH +: SAMPLE_BITS];
      meta_o.run        <= running_q;
      meta_o.course_out <= cnt_d >= cfg_i.dark_count_limit;
      meta_o.vel        <= velocity_term_i;
    end
  end

  // sensor left out of both halves when the count is odd
  assign odd_val = (SENSOR_COUNT % 2 == 1) ? store_q[SENSOR_COUNT-1] : '0;

  sums_match_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (TW'(lsum_q) + TW'(rsum_q) + TW'(odd_val)) == tot_q)
    else $error("running sums disagree with sensor store");

endmodule

>>> rtl/lfpd_steer.sv
// pd steering path: side difference, velocity clamp, gain products, floored term
// depends on lfpd_pkg

module lfpd_steer #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lfpd_pkg::lfpd_load_t                load_i,
  input  logic [SAMPLE_BITS-1:0]              left_mean_i,
  input  logic [SAMPLE_BITS-1:0]              right_mean_i,
  input  lfpd_pkg::lfpd_meta_t                meta_i,
  input  logic [15:0]                         kp_gain_i,
  input  logic [15:0]                         kd_rate_gain_i,
  input  logic [14:0]                         limit_i,
  output logic signed [SAMPLE_BITS+11:0]      steer_o,
  output lfpd_pkg::lfpd_meta_t                meta_o
);

  localparam int unsigned DW  = SAMPLE_BITS + 1;
  localparam int unsigned PKW = 17 + DW;
  localparam int unsigned PDW = 17 + DW + 1;
  localparam int unsigned PSW = 17 + DW + 2;

  logic signed [DW-1:0]  diff_q, diff_d, prev_q;
  logic signed [DW:0]    delta;
  logic signed [PKW-1:0] pkp_q;
  logic signed [PDW-1:0] pkd_q;
  logic signed [PSW-1:0] psum;
  logic signed [15:0]    lim_pos, lim_neg, vclamp;
  lfpd_pkg::lfpd_meta_t  m2_q, m3_q;

  // side difference and velocity clamp
  always_comb begin
    diff_d  = $signed({1'b0, left_mean_i}) - $signed({1'b0, right_mean_i});
    lim_pos = $signed({1'b0, limit_i});
    lim_neg = -lim_pos;
    if (meta_i.vel > lim_pos) begin
      vclamp = lim_pos;
    end else if (meta_i.vel < lim_neg) begin
      vclamp = lim_neg;
    end else begin
      vclamp = meta_i.vel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.s2) begin
      diff_q            <= diff_d;
      m2_q.run          <= meta_i.run;
      m2_q.course_out   <= meta_i.course_out;
      m2_q.vel          <= vclamp;
    end
  end

  // gain products
  assign delta = $signed({diff_q[DW-1], diff_q}) - $signed({prev_q[DW-1], prev_q});

  always_ff @(posedge clk_i) begin
    if (load_i.s3) begin
      pkp_q <= PKW'($signed({1'b0, kp_gain_i})) * PKW'(diff_q);
      pkd_q <= PDW'($signed({1'b0, kd_rate_gain_i})) * PDW'(delta);
      m3_q  <= m2_q;
    end
  end

  // previous difference moves only on running ticks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (load_i.s3 && m2_q.run) begin
      prev_q <= diff_q;
    end
  end

  // floored divide by 256 is the upper slice of the sum
  assign psum = $signed({pkp_q[PKW-1], pkp_q[PKW-1], pkp_q}) +
                $signed({pkd_q[PDW-1], pkd_q});

  always_ff @(posedge clk_i) begin
    if (load_i.s4) begin
      steer_o <= psum[PSW-1:8];
      meta_o  <= m3_q;
    end
  end

  prev_held_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i.s3 && !m2_q.run |=> $stable(prev_q))
    else $error("previous difference changed on a stopped tick");

  prev_follows_running_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i.s3 && m2_q.run |=> prev_q == $past(diff_q))
    else $error("previous difference not taken from running tick");

endmodule

>>> rtl/lfpd_mix.sv
// motor mixer: overshoot transfer, drive sums and 16-bit saturation
// depends on lfpd_pkg

module lfpd_mix #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lfpd_pkg::lfpd_load_t           load_i,
  input  logic signed [SAMPLE_BITS+11:0] steer_i,
  input  lfpd_pkg::lfpd_meta_t           meta_i,
  input  logic [14:0]                    max_period_i,
  output logic signed [15:0]             motor_left_o,
  output logic signed [15:0]             motor_right_o,
  output logic signed [15:0]             velocity_applied_o,
  output logic                           course_out_o
);

  localparam int unsigned SW = SAMPLE_BITS + 12;
  localparam int unsigned XW = SW + 1;
  localparam int unsigned EW = XW + 1;
  localparam int unsigned OW = EW + 2;
  localparam logic signed [OW-1:0] SMAX = OW'(32767);
  localparam logic signed [OW-1:0] SMIN = -SMAX - OW'(1);

  logic signed [XW-1:0] vx, sx, px, t_d, u_d, t_q, u_q;
  logic signed [EW-1:0] e_d, e_q;
  logic signed [15:0]   v5_q;
  logic                 run5_q, course5_q;
  logic signed [OW-1:0] left_w, right_w, appl_w;

  function automatic logic signed [15:0] sat16(input logic signed [OW-1:0] x);
    logic signed [15:0] r;
    if (x > SMAX) begin
      r = 16'sh7FFF;
    end else if (x < SMIN) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

  // drive sums and overshoot amount
  always_comb begin
    vx  = {{(XW-16){meta_i.vel[15]}}, meta_i.vel};
    sx  = {steer_i[SW-1], steer_i};
    px  = $signed({{(XW-15){1'b0}}, max_period_i});
    t_d = vx + sx;
    u_d = vx - sx;
    if (t_d >= px) begin
      e_d = $signed({t_d[XW-1], t_d}) - $signed({px[XW-1], px});
    end else if (u_d <= -px) begin
      e_d = -$signed({px[XW-1], px}) - $signed({u_d[XW-1], u_d});
    end else begin
      e_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.s5) begin
      t_q       <= t_d;
      u_q       <= u_d;
      e_q       <= e_d;
      v5_q      <= meta_i.vel;
      run5_q    <= meta_i.run;
      course5_q <= meta_i.course_out;
    end
  end

  // moving e from velocity to steering leaves v+s and takes 2e off v-s
  always_comb begin
    left_w  = {{(OW-XW){t_q[XW-1]}}, t_q};
    right_w = $signed({{(OW-XW){u_q[XW-1]}}, u_q}) -
              $signed({e_q[EW-1], e_q, 1'b0});
    appl_w  = $signed({{(OW-16){v5_q[15]}}, v5_q}) -
              $signed({{(OW-EW){e_q[EW-1]}}, e_q});
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load_i.s6) begin
      motor_left_o       <= run5_q ? sat16(left_w) : '0;
      motor_right_o      <= run5_q ? sat16(right_w) : '0;
      velocity_applied_o <= run5_q ? sat16(appl_w) : '0;
      course_out_o       <= course5_q;
    end
  end

  stopped_drives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i.s6 && !run5_q |=>
      motor_left_o == 16'sd0 && motor_right_o == 16'sd0 && velocity_applied_o == 16'sd0)
    else $error("drive nonzero while not running");

  overshoot_not_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i.s6 |-> !e_q[EW-1])
    else $error("negative overshoot amount");

endmodule

>>> rtl/line_follow_pd_motor_mixer.sv
// top level: config registers, input register, stage valids and the three datapath parts
// depends on lfpd_pkg, lfpd_sense, lfpd_steer, lfpd_mix
//
// a control tick's result passes the input register and stage registers 1 to 6 before it is valid
// throughput: one item per cycle, set by the 7-register pipeline with per-stage stall
// samples, start and stop are consumed at stage 1 and give no result
// reset clears sensor store, run flag, dark counter, previous difference and valids
// config registers reset to their defaults; no clearing pass is needed

module line_follow_pd_motor_mixer #(
  parameter int unsigned SENSOR_COUNT = 12,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lfpd_pkg::OP_W-1:0]           opcode_i,
  input  logic [3:0]                          sensor_index_i,
  input  logic [11:0]                         sensor_value_i,
  input  logic signed [15:0]                  velocity_term_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [15:0]                  motor_left_o,
  output logic signed [15:0]                  motor_right_o,
  output logic signed [15:0]                  velocity_applied_o,
  output logic                                course_out_o
);

  lfpd_pkg::lfpd_cfg_t  cfg_q;
  logic [14:0]          lim_q;
  logic [35:0]          lim_prod;

  logic                       in_v_q;
  logic [lfpd_pkg::OP_W-1:0]  op_q;
  logic [3:0]                 idx_q;
  logic [11:0]                val_q;
  logic signed [15:0]         vel_q;

  logic [5:1]           v_q;
  logic [6:0]           rdy;
  logic                 in_xfer, out_xfer;
  lfpd_pkg::lfpd_load_t load;

  logic [SAMPLE_BITS-1:0]          lmean, rmean;
  lfpd_pkg::lfpd_meta_t            meta1, meta4;
  logic signed [SAMPLE_BITS+11:0]  steer;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_gain          <= lfpd_pkg::KP_GAIN_RST;
      cfg_q.kd_rate_gain     <= lfpd_pkg::KD_GAIN_RST;
      cfg_q.max_period       <= lfpd_pkg::MAX_PERIOD_RST;
      cfg_q.dark_level       <= lfpd_pkg::DARK_LEVEL_RST;
      cfg_q.dark_count_limit <= lfpd_pkg::DARK_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfpd_pkg::REG_KP_GAIN:    cfg_q.kp_gain          <= cfg_wdata_i;
        lfpd_pkg::REG_KD_GAIN:    cfg_q.kd_rate_gain     <= cfg_wdata_i;
        lfpd_pkg::REG_MAX_PERIOD: cfg_q.max_period       <= cfg_wdata_i[14:0];
        lfpd_pkg::REG_DARK_LEVEL: cfg_q.dark_level       <= cfg_wdata_i[11:0];
        lfpd_pkg::REG_DARK_LIMIT: cfg_q.dark_count_limit <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // velocity limit floor(4p/5), refreshed every cycle
  assign lim_prod = 36'({cfg_q.max_period, 2'b00}) * 36'(lfpd_pkg::LIM_RECIP);

  always_ff @(posedge clk_i) begin
    lim_q <= lim_prod[lfpd_pkg::LIM_SHIFT +: 15];
  end

  // stall chain: a stage takes a transfer when empty or when it moves on
  always_comb begin
    rdy[6] = !out_valid_o || !out_stall_i;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    rdy[0]  = !in_v_q || rdy[1];
    load.s1 = in_v_q && rdy[1];
    load.s2 = v_q[1] && rdy[2];
    load.s3 = v_q[2] && rdy[3];
    load.s4 = v_q[3] && rdy[4];
    load.s5 = v_q[4] && rdy[5];
    load.s6 = v_q[5] && rdy[6];
  end

  assign in_stall_o = !rdy[0];
  assign in_xfer    = in_valid_i && rdy[0];
  assign out_xfer   = out_valid_o && !out_stall_i;

  // stage valids; only ticks go past stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q      <= 1'b0;
      v_q         <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_v_q <= 1'b1;
      end else if (load.s1) begin
        in_v_q <= 1'b0;
      end
      if (load.s1 && (op_q == lfpd_pkg::OP_TICK)) begin
        v_q[1] <= 1'b1;
      end else if (load.s2) begin
        v_q[1] <= 1'b0;
      end
      if (load.s2) begin
        v_q[2] <= 1'b1;
      end else if (load.s3) begin
        v_q[2] <= 1'b0;
      end
      if (load.s3) begin
        v_q[3] <= 1'b1;
      end else if (load.s4) begin
        v_q[3] <= 1'b0;
      end
      if (load.s4) begin
        v_q[4] <= 1'b1;
      end else if (load.s5) begin
        v_q[4] <= 1'b0;
      end
      if (load.s5) begin
        v_q[5] <= 1'b1;
      end else if (load.s6) begin
        v_q[5] <= 1'b0;
      end
      if (load.s6) begin
        out_valid_o <= 1'b1;
      end else if (out_xfer) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= opcode_i;
      idx_q <= sensor_index_i;
      val_q <= sensor_value_i;
      vel_q <= velocity_term_i;
    end
  end

  lfpd_sense #(
    .SENSOR_COUNT(SENSOR_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sense (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .opcode_i       (op_q),
    .sensor_index_i (idx_q),
    .sensor_value_i (val_q),
    .velocity_term_i(vel_q),
    .cfg_i          (cfg_q),
    .left_mean_o    (lmean),
    .right_mean_o   (rmean),
    .meta_o         (meta1)
  );

  lfpd_steer #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_steer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .left_mean_i   (lmean),
    .right_mean_i  (rmean),
    .meta_i        (meta1),
    .kp_gain_i     (cfg_q.kp_gain),
    .kd_rate_gain_i(cfg_q.kd_rate_gain),
    .limit_i       (lim_q),
    .steer_o       (steer),
    .meta_o        (meta4)
  );

  lfpd_mix #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mix (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (load),
    .steer_i           (steer),
    .meta_i            (meta4),
    .max_period_i      (cfg_q.max_period),
    .motor_left_o      (motor_left_o),
    .motor_right_o     (motor_right_o),
    .velocity_applied_o(velocity_applied_o),
    .course_out_o      (course_out_o)
  );

  non_tick_leaves_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load.s1 && (op_q != lfpd_pkg::OP_TICK) && !load.s2 |=> v_q[1] == $past(v_q[1]))
    else $error("non-tick item entered the steering pipeline");

endmodule
